// ===== hdl/stu_pkg.sv =====
// Shared types, character codes and helper functions for the source tokenizer.
// Used by the lexer front end, the token queue, the emitter and the top level.
`default_nettype none

package stu_pkg;

	// Width of the running byte position and of the comment nesting counter
	localparam int OFFSET_BITS = 24;
	localparam int DEPTH_BITS  = 8;

	// Reported field widths
	localparam int OFF_W  = 24;
	localparam int KIND_W = 3;

	// Up to three tokens per input beat
	localparam int MAX_RES  = 3;
	localparam int CNT_BITS = 2;

	// Token queue between front and back
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

	// Packed result width, padded to whole bytes
	localparam int REC_BITS   = KIND_W + 3 * OFF_W;
	localparam int TDATA_BITS = ((REC_BITS + 7) / 8) * 8;

	// Character codes
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;

	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [DEPTH_BITS-1:0]  depth_t;
	typedef logic [OFF_W-1:0]       off_t;

	typedef enum logic [KIND_W-1:0] {
		K_WS  = 3'd0,
		K_STR = 3'd1,
		K_NUM = 3'd2,
		K_ID  = 3'd3,
		K_SYM = 3'd4,
		K_END = 3'd5
	} token_kind_t;

	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_WS    = 7'b0000010,
		M_STR   = 7'b0000100,
		M_NUM   = 7'b0001000,
		M_ID    = 7'b0010000,
		M_LINE  = 7'b0100000,
		M_BLOCK = 7'b1000000
	} lex_mode_t;

	typedef struct packed {
		off_t        nl;
		off_t        stop;
		off_t        start;
		token_kind_t kind;
	} rec_t;

	// All tokens caused by one input beat
	typedef struct packed {
		logic [CNT_BITS-1:0]    count;
		rec_t [MAX_RES-1:0]     rec;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_idstart(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || (c == 8'h5f);
	endfunction

	// Report the low 24 bits of a position, zero-extended when narrower
	function automatic off_t rep(pos_t v);
		logic [OFFSET_BITS+OFF_W-1:0] w;
		w = (OFFSET_BITS + OFF_W)'(v);
		return w[OFF_W-1:0];
	endfunction

	// Append one token unless the bundle is already full
	function automatic bundle_t push_rec(bundle_t b, token_kind_t k, off_t s, off_t e, off_t nl);
		bundle_t r;
		r = b;
		if (b.count < CNT_BITS'(MAX_RES)) begin
			r.rec[b.count].kind  = k;
			r.rec[b.count].start = s;
			r.rec[b.count].stop  = e;
			r.rec[b.count].nl    = nl;
			r.count = b.count + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/stu_lexer.sv =====
// Front end: classifies each accepted byte, updates the lexer state and
// builds the bundle of tokens it causes. Depends on stu_pkg.
`default_nettype none

module stu_lexer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      in_byte,
	input  wire logic            has_byte,
	input  wire logic            source_end,
	output      logic            push,
	output      stu_pkg::bundle_t bundle
);
	import stu_pkg::*;

	lex_mode_t   mode_q, mode_d;
	logic [7:0]  held_q, held_d;
	logic        hv_q, hv_d;
	pos_t        pos_q, pos_d, pos_inc, pos_dec, end_dec;
	pos_t        begin_q, begin_d;
	depth_t      depth_q, depth_d;
	logic        esc_q, esc_d;
	logic        quote_q, quote_d;
	off_t        tally_q, tally_d;
	bundle_t     bun;
	logic        done;
	logic        start;

	assign pos_inc = pos_q + pos_t'(1);
	assign pos_dec = pos_q - pos_t'(1);

	// Next state and emitted tokens for one beat
	always_comb begin
		mode_d  = mode_q;
		held_d  = held_q;
		hv_d    = hv_q;
		pos_d   = pos_q;
		begin_d = begin_q;
		depth_d = depth_q;
		esc_d   = esc_q;
		quote_d = quote_q;
		tally_d = tally_q;
		bun     = '0;
		done    = 1'b0;
		start   = 1'b0;
		end_dec = '0;

		if (has_byte) begin
			pos_d = pos_inc;
			// resolve the held byte against this one
			if (hv_q) begin
				hv_d   = 1'b0;
				held_d = '0;
				if (mode_q == M_BLOCK) begin
					if (held_q == CH_SLASH && in_byte == CH_STAR) begin
						if (depth_q != '1)
							depth_d = depth_q + 1'b1;
						done = 1'b1;
					end else if (held_q == CH_STAR && in_byte == CH_SLASH) begin
						if (depth_q != '0)
							depth_d = depth_q - 1'b1;
						if (depth_d == '0)
							mode_d = M_IDLE;
						done = 1'b1;
					end
				end else if (held_q == CH_SLASH) begin
					if (in_byte == CH_SLASH) begin
						mode_d = M_LINE;
						done   = 1'b1;
					end else if (in_byte == CH_STAR) begin
						mode_d  = M_BLOCK;
						depth_d = depth_t'(1);
						done    = 1'b1;
					end else begin
						bun = push_rec(bun, K_SYM, rep(pos_dec), rep(pos_q), '0);
					end
				end else begin
					if (is_digit(in_byte)) begin
						mode_d  = M_NUM;
						begin_d = pos_dec;
						done    = 1'b1;
					end else begin
						bun = push_rec(bun, K_SYM, rep(pos_dec), rep(pos_q), '0);
					end
				end
			end

			// advance the open token
			if (!done) begin
				unique case (mode_d)
					M_WS: begin
						if (is_space(in_byte)) begin
							if (in_byte == CH_LF && tally_q != '1)
								tally_d = tally_q + 1'b1;
						end else begin
							bun = push_rec(bun, K_WS, rep(begin_q), rep(pos_q), tally_q);
							tally_d = '0;
							start = 1'b1;
						end
					end
					M_STR: begin
						if (esc_q) begin
							esc_d = 1'b0;
						end else if (in_byte == CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (in_byte == (quote_q ? CH_SQUOTE : CH_DQUOTE)) begin
							bun = push_rec(bun, K_STR, rep(begin_q), rep(pos_inc), '0);
							mode_d = M_IDLE;
						end
					end
					M_NUM: begin
						if (!(is_digit(in_byte) || in_byte == CH_DOT)) begin
							bun = push_rec(bun, K_NUM, rep(begin_d), rep(pos_q), '0);
							start = 1'b1;
						end
					end
					M_ID: begin
						if (!(is_idstart(in_byte) || is_digit(in_byte))) begin
							bun = push_rec(bun, K_ID, rep(begin_q), rep(pos_q), '0);
							start = 1'b1;
						end
					end
					M_LINE: begin
						if (in_byte == CH_LF)
							start = 1'b1;
					end
					M_BLOCK: begin
						if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
							held_d = in_byte;
							hv_d   = 1'b1;
						end
					end
					M_IDLE: begin
						start = 1'b1;
					end
					default: begin
						start = 1'b1;
					end
				endcase
			end

			// open a new token at this byte
			if (start) begin
				mode_d  = M_IDLE;
				begin_d = pos_q;
				if (is_space(in_byte)) begin
					mode_d  = M_WS;
					tally_d = (in_byte == CH_LF) ? off_t'(1) : '0;
				end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
					mode_d  = M_STR;
					quote_d = (in_byte == CH_SQUOTE);
					esc_d   = 1'b0;
				end else if (is_digit(in_byte)) begin
					mode_d = M_NUM;
				end else if (is_idstart(in_byte)) begin
					mode_d = M_ID;
				end else if (in_byte == CH_SLASH || in_byte == CH_PLUS || in_byte == CH_MINUS) begin
					held_d = in_byte;
					hv_d   = 1'b1;
				end else begin
					bun = push_rec(bun, K_SYM, rep(pos_q), rep(pos_inc), '0);
				end
			end
		end

		// flush at end of source and return to reset
		if (source_end) begin
			end_dec = pos_d - pos_t'(1);
			if (hv_d && mode_d != M_BLOCK)
				bun = push_rec(bun, K_SYM, rep(end_dec), rep(pos_d), '0);
			unique case (mode_d)
				M_WS:    bun = push_rec(bun, K_WS, rep(begin_d), rep(pos_d), tally_d);
				M_STR:   bun = push_rec(bun, K_STR, rep(begin_d), rep(pos_d), '0);
				M_NUM:   bun = push_rec(bun, K_NUM, rep(begin_d), rep(pos_d), '0);
				M_ID:    bun = push_rec(bun, K_ID, rep(begin_d), rep(pos_d), '0);
				M_IDLE, M_LINE, M_BLOCK: begin
				end
				default: begin
				end
			endcase
			bun = push_rec(bun, K_END, rep(pos_d), rep(pos_d), '0);
			mode_d  = M_IDLE;
			held_d  = '0;
			hv_d    = 1'b0;
			pos_d   = '0;
			begin_d = '0;
			depth_d = '0;
			esc_d   = 1'b0;
			quote_d = 1'b0;
			tally_d = '0;
		end
	end

	assign push   = accept && (bun.count != '0);
	assign bundle = bun;

	// Hold lexer state between accepted beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			held_q  <= '0;
			hv_q    <= 1'b0;
			pos_q   <= '0;
			begin_q <= '0;
			depth_q <= '0;
			esc_q   <= 1'b0;
			quote_q <= 1'b0;
			tally_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			hv_q    <= hv_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			depth_q <= depth_d;
			esc_q   <= esc_d;
			quote_q <= quote_d;
			tally_q <= tally_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/stu_queue.sv =====
// Token queue: a short FIFO of token bundles between lexer and emitter.
// Depends on stu_pkg.
`default_nettype none

module stu_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stu_pkg::bundle_t wr_data,
	input  wire logic             pop,
	output      stu_pkg::bundle_t rd_data,
	output      stu_pkg::q_status_t status
);
	import stu_pkg::*;

	bundle_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]   wr_ptr_q;
	logic [Q_PTR_BITS-1:0]   rd_ptr_q;
	logic [Q_PTR_BITS:0]     cnt_q;

	assign status.full  = (cnt_q == (Q_PTR_BITS + 1)'(Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign rd_data      = mem_q[rd_ptr_q];

	// Store bundles
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_PTR_BITS + 1)'(Q_DEPTH))
		else $error("token queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("token queue popped while empty");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("token queue count did not grow on push");
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> rd_data.count != '0)
		else $error("token queue holds an empty bundle");
`endif

endmodule

`default_nettype wire

// ===== hdl/stu_emitter.sv =====
// Back end: walks the head bundle one token per cycle while not stalled
// into a registered output beat, pops it after its last token. Depends on stu_pkg.
`default_nettype none

module stu_emitter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire stu_pkg::bundle_t   head,
	input  wire stu_pkg::q_status_t status,
	output      logic               pop,
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [stu_pkg::TDATA_BITS-1:0] m_tdata,  // kind, start, end, newlines, zero pad
	output      logic               m_tlast                // last token of the input beat
);
	import stu_pkg::*;

	logic [CNT_BITS-1:0] idx_q;
	logic                valid_q;
	rec_t                rec_q;
	logic                last_q;
	logic                load;
	logic                is_last;

	assign load    = !status.empty && (!valid_q || m_tready);
	assign is_last = (idx_q == head.count - 1'b1);
	assign pop     = load && is_last;

	// Load the next token into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			rec_q  <= head.rec[idx_q];
			last_q <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TDATA_BITS'(rec_q);
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== hdl/source_tokenizer_unit.sv =====
// Top level of the source tokenizer: lexer front end, token queue, emitter.
// Depends on stu_pkg, stu_lexer, stu_queue and stu_emitter.
//
// Usage:
//   Slave stream carries one source byte per beat: s_tdata is the byte,
//   s_tuser says a byte is present, s_tlast marks the end of the source.
//   Master stream carries one token per beat: kind, start offset, end offset
//   and newline count in m_tdata; m_tlast flags the last token caused by
//   one input beat. A beat may cause zero to three tokens.
//   A token is registered in the queue, then in the emitter output register.
//   The lexer takes one byte per cycle while the queue is not full; the master
//   side drains one token per cycle while m_tready is high, so sustained rate
//   is one byte per cycle as long as tokens average at most one per byte.
//   A four-bundle queue separates the two sides: when the receiver stalls,
//   bytes are still taken until the queue fills, then s_tready drops.
//   Reset clears the lexer state, the byte offset and the queue; the end of
//   the source returns the lexer to the same state after its end token.
`default_nettype none

module source_tokenizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // in_byte
	input  wire logic        s_tuser,   // has_byte
	input  wire logic        s_tlast,   // source_end
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [stu_pkg::TDATA_BITS-1:0] m_tdata,  // token_kind, start_offset,
	                                                       // end_offset, newline_count
	output      logic        m_tlast    // last_of_run
);
	import stu_pkg::*;

	logic      accept;
	logic      push;
	logic      pop;
	bundle_t   wr_bundle;
	bundle_t   head;
	q_status_t status;

	assign s_tready = !status.full;
	assign accept   = s_tvalid && s_tready;

	stu_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (s_tdata),
		.has_byte   (s_tuser),
		.source_end (s_tlast),
		.push       (push),
		.bundle     (wr_bundle)
	);

	stu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.status  (status)
	);

	stu_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
